/* rtl/bsac_pkg.sv */
// ----------------------------------------------------------------------------
// bsac_pkg
// shared types and constants of the bounded-step array counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsac_pkg;

    // width of one count and of the result
    localparam int COUNT_W = 30;
    // width of an entry value and of the max_value register
    localparam int VALUE_W = 8;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [VALUE_W-1:0] t_value;

    // counts are kept modulo this prime
    localparam t_count MODULUS = 30'd1000000007;

endpackage

/* rtl/bsac_item_if.sv */
// ----------------------------------------------------------------------------
// bsac_item_if
// input channel: one array entry per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsac_item_if;
    logic              valid;
    logic              ready;
    bsac_pkg::t_value  entry_value;
    logic              last_entry;

    modport source (output valid, output entry_value, output last_entry, input ready);
    modport sink   (input valid, input entry_value, input last_entry, output ready);
endinterface

/* rtl/bsac_result_if.sv */
// ----------------------------------------------------------------------------
// bsac_result_if
// output channel: one array count per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsac_result_if;
    logic              valid;
    logic              ready;
    bsac_pkg::t_count  array_count;

    modport source (output valid, output array_count, input ready);
    modport sink   (input valid, input array_count, output ready);
endinterface

/* rtl/bsac_cfg_if.sv */
// ----------------------------------------------------------------------------
// bsac_cfg_if
// configuration write channel for the max_value register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsac_cfg_if;
    logic              valid;
    logic              ready;
    bsac_pkg::t_value  max_value;

    modport source (output valid, output max_value, input ready);
    modport sink   (input valid, input max_value, output ready);
endinterface

/* rtl/bsac_mod_add3.sv */
// ----------------------------------------------------------------------------
// bsac_mod_add3
// three-operand adder modulo the prime, operands already reduced
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsac_mod_add3 (
    input  bsac_pkg::t_count i_a,
    input  bsac_pkg::t_count i_b,
    input  bsac_pkg::t_count i_c,
    output bsac_pkg::t_count o_sum
);

    localparam int SUM_W = bsac_pkg::COUNT_W + 2;

    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_mod1;
    logic [SUM_W-1:0] w_mod2;

    assign w_mod1 = SUM_W'(bsac_pkg::MODULUS);
    assign w_mod2 = w_mod1 << 1;
    assign w_sum  = SUM_W'(i_a) + SUM_W'(i_b) + SUM_W'(i_c);

    // sum stays below three times the modulus: one of two corrections
    always_comb begin
        priority if (w_sum >= w_mod2) begin
            o_sum = bsac_pkg::COUNT_W'(w_sum - w_mod2);
        end else if (w_sum >= w_mod1) begin
            o_sum = bsac_pkg::COUNT_W'(w_sum - w_mod1);
        end else begin
            o_sum = bsac_pkg::COUNT_W'(w_sum);
        end
    end

endmodule

/* rtl/bounded_step_array_count.sv */
// ----------------------------------------------------------------------------
// bounded_step_array_count
// counts arrays with entries in 1..max_value whose neighbors differ by at
// most one, modulo 1e9+7, from a stream of free or fixed entries
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                         transfer when
//  i_item    in         entry_value[7:0], last_entry    valid & ready
//  o_result  out        array_count[29:0]               valid & ready
//  i_cfg     in         max_value[7:0]                  valid & ready
//
//  each entry passes through, in order, the accept state, the read-ahead
//  states LOAD0 and LOAD1, one pass of the shared modular adder over the
//  count memory up to the effective bound m, the write-back state DRAIN and
//  the finish state; ready stays low until the sequencer is back in idle
//  reset is synchronous, active low; the count memory has no reset
//  on the last entry the finish cycle holds while an earlier result is still
//  waiting in the output register; otherwise output stalls do not stop work
//
`timescale 1ns / 1ps

module bounded_step_array_count #(
    parameter int MAX_VALUE_BOUND = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bsac_item_if.sink            i_item,
    bsac_result_if.source        o_result,
    bsac_cfg_if.sink             i_cfg
);

    // widths derived from the bound
    localparam int MW = $clog2(MAX_VALUE_BOUND + 1);   // holds 0..bound
    localparam int AW = $clog2(MAX_VALUE_BOUND);       // memory address
    localparam int VW = bsac_pkg::VALUE_W;
    localparam int CW = ((MW > VW) ? MW : VW) + 1;     // compare width

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD0  = 3'd1;
    localparam logic [2:0] S_LOAD1  = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    // control state
    logic [2:0]             r_state, n_state;
    logic                   r_first_pending;
    bsac_pkg::t_value       r_max_value;
    logic                   r_wr_en;
    logic                   r_out_valid;

    // item and datapath registers
    bsac_pkg::t_value       r_v;
    logic                   r_last;
    logic                   r_first;
    logic [MW-1:0]          r_m;
    logic [MW-1:0]          r_prev_m;
    logic [MW-1:0]          r_j;
    bsac_pkg::t_count       r_left;
    bsac_pkg::t_count       r_cur;
    bsac_pkg::t_count       r_rd_data;
    logic [AW-1:0]          r_wr_addr;
    bsac_pkg::t_count       r_wr_val;
    bsac_pkg::t_count       r_total;
    bsac_pkg::t_count       r_out_data;

    // count memory, one count per possible entry value
    bsac_pkg::t_count       r_mem [MAX_VALUE_BOUND];

    logic                   w_item_xfer;
    logic                   w_out_xfer;
    logic                   w_out_load;
    logic [CW-1:0]          w_cfg_ext;
    logic [CW-1:0]          w_bound_ext;
    logic [CW-1:0]          w_eff_ext;
    logic [MW-1:0]          w_eff_m;
    logic [MW:0]            w_jx;
    logic [MW:0]            w_j1;
    logic [MW:0]            w_rd_sum;
    logic [AW-1:0]          w_rd_addr;
    logic                   w_left_ok;
    logic                   w_cur_ok;
    logic                   w_right_ok;
    logic                   w_keep;
    bsac_pkg::t_count       w_op_a;
    bsac_pkg::t_count       w_op_b;
    bsac_pkg::t_count       w_op_c;
    bsac_pkg::t_count       w_nsum;
    bsac_pkg::t_count       w_next;
    bsac_pkg::t_count       w_total_sum;

    assign i_item.ready        = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_result.valid      = r_out_valid;
    assign o_result.array_count = r_out_data;

    assign w_item_xfer = i_item.valid & i_item.ready;
    assign w_out_xfer  = r_out_valid & o_result.ready;
    // result goes to the output register once the previous one has left
    assign w_out_load  = (r_state == S_FINISH) & r_last & (~r_out_valid | o_result.ready);

    // effective bound: zero acts as one, saturates at the bound
    assign w_cfg_ext   = CW'(r_max_value);
    assign w_bound_ext = CW'(MAX_VALUE_BOUND);
    always_comb begin
        priority if (r_max_value == '0) begin
            w_eff_ext = CW'(1);
        end else if (w_cfg_ext > w_bound_ext) begin
            w_eff_ext = w_bound_ext;
        end else begin
            w_eff_ext = w_cfg_ext;
        end
    end
    assign w_eff_m = w_eff_ext[MW-1:0];

    // neighbor window: left = prev[j-1], cur = prev[j], read data = prev[j+1]
    // counts past the previous item's bound read as zero
    assign w_jx       = {1'b0, r_j};
    assign w_j1       = w_jx + (MW+1)'(1);
    assign w_left_ok  = (r_j != '0) & (r_j <= r_prev_m);
    assign w_cur_ok   = (r_j < r_prev_m);
    assign w_right_ok = (w_j1 < {1'b0, r_m}) & (w_j1 < {1'b0, r_prev_m});

    assign w_op_a = w_left_ok  ? r_left    : '0;
    assign w_op_b = w_cur_ok   ? r_cur     : '0;
    assign w_op_c = w_right_ok ? r_rd_data : '0;

    bsac_mod_add3 u_step_add (
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .i_c   (w_op_c),
        .o_sum (w_nsum)
    );

    // a fixed entry keeps only its own count, a free entry keeps all
    assign w_keep = (r_v == '0) | (CW'(r_v) == CW'(w_j1));
    assign w_next = ~w_keep ? '0 :
                    r_first ? bsac_pkg::COUNT_W'(1) : w_nsum;

    // running total of the counts as they are written back
    bsac_mod_add3 u_total_add (
        .i_a   (r_total),
        .i_b   (r_wr_val),
        .i_c   ('0),
        .o_sum (w_total_sum)
    );

    // read two entries ahead of the one being computed
    assign w_rd_sum = w_jx + (MW+1)'(2);
    always_comb begin
        priority case (r_state)
            S_LOAD0: w_rd_addr = '0;
            S_LOAD1: w_rd_addr = AW'(1);
            default: w_rd_addr = w_rd_sum[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_rd_addr];
        if (r_wr_en) begin
            r_mem[r_wr_addr] <= r_wr_val;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_item_xfer) begin
                    n_state = S_LOAD0;
                end
            end
            S_LOAD0:  n_state = S_LOAD1;
            S_LOAD1:  n_state = S_RUN;
            S_RUN: begin
                if (w_j1 == {1'b0, r_m}) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: begin
                if (~r_last | w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_first_pending <= 1'b1;
            r_max_value     <= bsac_pkg::VALUE_W'(1);
            r_wr_en         <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wr_en <= (r_state == S_RUN);
            if (i_cfg.valid) begin
                r_max_value <= i_cfg.max_value;
            end
            if (r_state == S_FINISH && n_state == S_IDLE) begin
                r_first_pending <= r_last;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_item_xfer) begin
            r_v      <= i_item.entry_value;
            r_last   <= i_item.last_entry;
            r_first  <= r_first_pending;
            r_m      <= w_eff_m;
            r_prev_m <= r_m;
            r_j      <= '0;
            r_total  <= '0;
        end else if (r_wr_en) begin
            r_total  <= w_total_sum;
        end
        if (r_state == S_LOAD1) begin
            r_cur <= r_rd_data;
        end else if (r_state == S_RUN) begin
            r_left    <= r_cur;
            r_cur     <= r_rd_data;
            r_j       <= w_j1[MW-1:0];
            r_wr_addr <= r_j[AW-1:0];
            r_wr_val  <= w_next;
        end
        if (w_out_load) begin
            r_out_data <= (r_m == MW'(1)) ? bsac_pkg::COUNT_W'(1) : r_total;
        end
    end

endmodule
